// ----- hdl/sack_pkg.sv -----
// Shared types and constants for the selective-ack send window.
package sack_pkg;

    localparam int SEQ_W = 64;
    localparam int CNT_W = 11;
    localparam int OP_W  = 2;
    localparam int CFG_W = 64;
    localparam int IDX_W = 2;

    localparam logic [CNT_W-1:0] SOURCE_MAX = 11'd1024;
    localparam int               LIMIT_MAX  = 1024;

    localparam logic [OP_W-1:0] OP_ACK   = 2'd0;
    localparam logic [OP_W-1:0] OP_KICK  = 2'd1;
    localparam logic [OP_W-1:0] OP_START = 2'd2;

    localparam logic [IDX_W-1:0] REG_INITIAL_WINDOW = 2'd0;
    localparam logic [IDX_W-1:0] REG_FIRST_SEQ      = 2'd1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_POP_RD,
        ST_POP_CHK,
        ST_ISSUE,
        ST_CLEAR,
        ST_OUT
    } state_t;

endpackage

// ----- hdl/sack_if.sv -----
// Input and result channel interfaces of the selective-ack send window.
interface sack_in_if;
    logic                        valid;
    logic                        ready;
    logic [sack_pkg::OP_W-1:0]   op;
    logic [sack_pkg::SEQ_W-1:0]  seq_no;
    logic [sack_pkg::CNT_W-1:0]  source_left;

    modport source (output valid, output op, output seq_no, output source_left,
                    input ready);
    modport sink (input valid, input op, input seq_no, input source_left,
                  output ready);
endinterface

interface sack_out_if;
    logic                        valid;
    logic                        ready;
    logic [sack_pkg::SEQ_W-1:0]  resend_first;
    logic [sack_pkg::CNT_W-1:0]  resend_count;
    logic [sack_pkg::SEQ_W-1:0]  new_first;
    logic [sack_pkg::CNT_W-1:0]  new_count;
    logic [sack_pkg::CNT_W-1:0]  in_flight;
    logic                        ack_matched;
    logic                        done_res;

    modport source (output valid, output resend_first, output resend_count,
                    output new_first, output new_count, output in_flight,
                    output ack_matched, output done_res, input ready);
    modport sink (input valid, input resend_first, input resend_count,
                  input new_first, input new_count, input in_flight,
                  input ack_matched, input done_res, output ready);
endinterface

// ----- hdl/sack_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module sack_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1024
) (
    input  logic                             clk,
    input  logic                             we,
    input  logic [$clog2(DEPTH)-1:0]         waddr,
    input  logic [WIDTH-1:0]                 wdata,
    input  logic [$clog2(DEPTH)-1:0]         raddr,
    output logic [WIDTH-1:0]                 rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- hdl/selective_ack_send_window_core.sv -----
// Top level of the selective-ack send window: control, window state and bitmap.
//
// Usage:
//   in_ch carries one item per valid/ready handshake: op (ack, kick, start),
//   seq_no for acks, and source_left, the objects the source can deliver now.
//   out_ch returns exactly one result per item through an output register.
//   cfg_we/cfg_index/cfg_wdata write initial_window (0) and first_seq (1); the user
//   must write them only while the block is idle, and the block leaves this to the user.
// Sequence:
//   An accepted item walks the pop states, reading the bitmap entry at the window base
//   (registered read) and popping each acked entry from the front; it then issues the new
//   numbers, clearing each issued number's entry through the single write port, and
//   loads the result register. The next item is accepted at the earliest in the cycle
//   after the result has been loaded.
// Reset:
//   Window base and next sequence go to zero, the limit to one; the bitmap is
//   not cleared, since every entry is cleared when its number is issued.
// Stall:
//   A result not taken holds in the output register; the finished item waits
//   in its last state and no new item is accepted until the register frees.
module selective_ack_send_window_core #(
    parameter int MAX_WINDOW = 1024
) (
    input  logic                           clk,
    input  logic                           rst_n,
    sack_in_if.sink                        in_ch,
    sack_out_if.source                     out_ch,
    input  logic                           cfg_we,
    input  logic [sack_pkg::IDX_W-1:0]     cfg_index,
    input  logic [sack_pkg::CFG_W-1:0]     cfg_wdata
);

    localparam int AW = $clog2(MAX_WINDOW);
    localparam int CW = sack_pkg::CNT_W;
    localparam int SW = sack_pkg::SEQ_W;
    localparam int LIMIT_CAP = (MAX_WINDOW < sack_pkg::LIMIT_MAX) ? MAX_WINDOW
                                                                  : sack_pkg::LIMIT_MAX;
    localparam logic [CW-1:0] CAP       = CW'(LIMIT_CAP);
    localparam logic [AW-1:0] SLOT_LAST = AW'(MAX_WINDOW - 1);
    localparam logic [AW:0]   SLOT_DEPTH = (AW + 1)'(MAX_WINDOW);

    sack_pkg::state_t state_reg, state_next;

    logic [CW-1:0] init_window_reg, init_window_next;
    logic [SW-1:0] first_seq_reg, first_seq_next;

    logic [SW-1:0] base_reg, base_next;
    logic [SW-1:0] next_seq_reg, next_seq_next;
    logic [CW-1:0] limit_reg, limit_next;
    logic [CW-1:0] count_reg, count_next;
    logic [AW-1:0] base_slot_reg, base_slot_next;
    logic [AW-1:0] next_slot_reg, next_slot_next;

    logic [CW-1:0] left_reg, left_next;
    logic [CW-1:0] clr_left_reg, clr_left_next;
    logic [SW-1:0] rs_first_reg, rs_first_next;
    logic [CW-1:0] rs_count_reg, rs_count_next;
    logic [SW-1:0] nw_first_reg, nw_first_next;
    logic [CW-1:0] nw_count_reg, nw_count_next;
    logic          matched_reg, matched_next;

    logic          out_valid_reg, out_valid_next;
    logic [SW-1:0] o_rs_first_reg, o_rs_first_next;
    logic [CW-1:0] o_rs_count_reg, o_rs_count_next;
    logic [SW-1:0] o_nw_first_reg, o_nw_first_next;
    logic [CW-1:0] o_nw_count_reg, o_nw_count_next;
    logic [CW-1:0] o_flight_reg, o_flight_next;
    logic          o_matched_reg, o_matched_next;
    logic          o_done_reg, o_done_next;

    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic          mem_wdata;
    logic          mem_rdata;

    logic [SW-1:0] ack_off;
    logic          ack_hit;
    logic [AW:0]   ack_sum;
    logic [AW-1:0] ack_slot;
    logic [CW-1:0] room;
    logic [CW-1:0] issue_cnt;
    logic          in_fire;

    sack_ram #(
        .WIDTH (1),
        .DEPTH (MAX_WINDOW)
    ) u_acked (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (base_slot_reg),
        .rdata (mem_rdata)
    );

    assign in_fire = in_ch.valid && in_ch.ready;

    assign ack_off = in_ch.seq_no - base_reg;
    assign ack_hit = (ack_off[SW-1:CW] == '0) && (ack_off[CW-1:0] < count_reg);
    assign ack_sum = {1'b0, base_slot_reg} + {1'b0, ack_off[AW-1:0]};
    assign ack_slot = (ack_sum >= SLOT_DEPTH) ? AW'(ack_sum - SLOT_DEPTH) : ack_sum[AW-1:0];

    assign room = (limit_reg > count_reg) ? (limit_reg - count_reg) : '0;
    assign issue_cnt = (room < left_reg) ? room : left_reg;

    assign in_ch.ready         = (state_reg == sack_pkg::ST_IDLE);
    assign out_ch.valid        = out_valid_reg;
    assign out_ch.resend_first = o_rs_first_reg;
    assign out_ch.resend_count = o_rs_count_reg;
    assign out_ch.new_first    = o_nw_first_reg;
    assign out_ch.new_count    = o_nw_count_reg;
    assign out_ch.in_flight    = o_flight_reg;
    assign out_ch.ack_matched  = o_matched_reg;
    assign out_ch.done_res     = o_done_reg;

    always_comb
    begin
        state_next       = state_reg;
        init_window_next = init_window_reg;
        first_seq_next   = first_seq_reg;
        base_next        = base_reg;
        next_seq_next    = next_seq_reg;
        limit_next       = limit_reg;
        count_next       = count_reg;
        base_slot_next   = base_slot_reg;
        next_slot_next   = next_slot_reg;
        left_next        = left_reg;
        clr_left_next    = clr_left_reg;
        rs_first_next    = rs_first_reg;
        rs_count_next    = rs_count_reg;
        nw_first_next    = nw_first_reg;
        nw_count_next    = nw_count_reg;
        matched_next     = matched_reg;
        out_valid_next   = out_valid_reg;
        o_rs_first_next  = o_rs_first_reg;
        o_rs_count_next  = o_rs_count_reg;
        o_nw_first_next  = o_nw_first_reg;
        o_nw_count_next  = o_nw_count_reg;
        o_flight_next    = o_flight_reg;
        o_matched_next   = o_matched_reg;
        o_done_next      = o_done_reg;
        mem_we           = 1'b0;
        mem_waddr        = next_slot_reg;
        mem_wdata        = 1'b0;

        if (cfg_we)
        begin
            unique case (cfg_index)
                sack_pkg::REG_INITIAL_WINDOW: init_window_next = cfg_wdata[CW-1:0];
                sack_pkg::REG_FIRST_SEQ:      first_seq_next   = cfg_wdata;
                default:                      ;
            endcase
        end

        if (out_valid_reg && out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            sack_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    left_next     = (in_ch.source_left > sack_pkg::SOURCE_MAX)
                                    ? sack_pkg::SOURCE_MAX : in_ch.source_left;
                    rs_first_next = '0;
                    rs_count_next = '0;
                    matched_next  = 1'b0;
                    state_next    = sack_pkg::ST_POP_RD;
                    unique case (in_ch.op)
                        sack_pkg::OP_START:
                        begin
                            base_next      = first_seq_reg;
                            next_seq_next  = first_seq_reg;
                            count_next     = '0;
                            base_slot_next = '0;
                            next_slot_next = '0;
                            limit_next     = (init_window_reg > CAP) ? CAP : init_window_reg;
                        end
                        sack_pkg::OP_ACK:
                        begin
                            if (ack_hit)
                            begin
                                mem_we       = 1'b1;
                                mem_waddr    = ack_slot;
                                mem_wdata    = 1'b1;
                                matched_next = 1'b1;
                                if (limit_reg < CAP)
                                begin
                                    limit_next = limit_reg + 1'b1;
                                end
                            end
                        end
                        sack_pkg::OP_KICK:
                        begin
                            rs_first_next = base_reg;
                            rs_count_next = count_reg;
                        end
                        default: ;
                    endcase
                end
            end
            sack_pkg::ST_POP_RD:
            begin
                state_next = (count_reg == '0) ? sack_pkg::ST_ISSUE : sack_pkg::ST_POP_CHK;
            end
            sack_pkg::ST_POP_CHK:
            begin
                if (mem_rdata)
                begin
                    base_next      = base_reg + 1'b1;
                    count_next     = count_reg - 1'b1;
                    base_slot_next = (base_slot_reg == SLOT_LAST) ? '0
                                                                  : base_slot_reg + 1'b1;
                    state_next     = sack_pkg::ST_POP_RD;
                end
                else
                begin
                    state_next = sack_pkg::ST_ISSUE;
                end
            end
            sack_pkg::ST_ISSUE:
            begin
                nw_count_next = issue_cnt;
                clr_left_next = issue_cnt;
                nw_first_next = (issue_cnt != '0) ? next_seq_reg : '0;
                state_next    = (issue_cnt != '0) ? sack_pkg::ST_CLEAR : sack_pkg::ST_OUT;
            end
            sack_pkg::ST_CLEAR:
            begin
                mem_we         = 1'b1;
                mem_waddr      = next_slot_reg;
                mem_wdata      = 1'b0;
                next_seq_next  = next_seq_reg + 1'b1;
                count_next     = count_reg + 1'b1;
                next_slot_next = (next_slot_reg == SLOT_LAST) ? '0 : next_slot_reg + 1'b1;
                clr_left_next  = clr_left_reg - 1'b1;
                if (clr_left_reg == CW'(1))
                begin
                    state_next = sack_pkg::ST_OUT;
                end
            end
            sack_pkg::ST_OUT:
            begin
                if (!out_valid_reg || out_ch.ready)
                begin
                    out_valid_next  = 1'b1;
                    o_rs_first_next = rs_first_reg;
                    o_rs_count_next = rs_count_reg;
                    o_nw_first_next = nw_first_reg;
                    o_nw_count_next = nw_count_reg;
                    o_flight_next   = count_reg;
                    o_matched_next  = matched_reg;
                    o_done_next     = (count_reg == '0);
                    state_next      = sack_pkg::ST_IDLE;
                end
            end
            default: state_next = sack_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sack_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_window_reg <= CW'(1);
            first_seq_reg   <= '0;
            base_reg        <= '0;
            next_seq_reg    <= '0;
            limit_reg       <= CW'(1);
            count_reg       <= '0;
            base_slot_reg   <= '0;
            next_slot_reg   <= '0;
            clr_left_reg    <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            init_window_reg <= init_window_next;
            first_seq_reg   <= first_seq_next;
            base_reg        <= base_next;
            next_seq_reg    <= next_seq_next;
            limit_reg       <= limit_next;
            count_reg       <= count_next;
            base_slot_reg   <= base_slot_next;
            next_slot_reg   <= next_slot_next;
            clr_left_reg    <= clr_left_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        left_reg       <= left_next;
        rs_first_reg   <= rs_first_next;
        rs_count_reg   <= rs_count_next;
        nw_first_reg   <= nw_first_next;
        nw_count_reg   <= nw_count_next;
        matched_reg    <= matched_next;
        o_rs_first_reg <= o_rs_first_next;
        o_rs_count_reg <= o_rs_count_next;
        o_nw_first_reg <= o_nw_first_next;
        o_nw_count_reg <= o_nw_count_next;
        o_flight_reg   <= o_flight_next;
        o_matched_reg  <= o_matched_next;
        o_done_reg     <= o_done_next;
    end

    a_flight_within_limit: assert property (
        @(posedge clk) disable iff (!rst_n)
        count_reg <= limit_reg && limit_reg <= CAP)
        else $error("in-flight count exceeds window limit");

    a_window_span: assert property (
        @(posedge clk) disable iff (!rst_n)
        state_reg == sack_pkg::ST_IDLE |-> next_seq_reg - base_reg == SW'(count_reg))
        else $error("window span disagrees with in-flight count");

    a_clear_nonzero: assert property (
        @(posedge clk) disable iff (!rst_n)
        state_reg == sack_pkg::ST_CLEAR |-> clr_left_reg != '0)
        else $error("clear sweep entered with nothing to issue");

    a_accept_leaves_idle: assert property (
        @(posedge clk) disable iff (!rst_n)
        in_fire |=> state_reg == sack_pkg::ST_POP_RD)
        else $error("accepted item did not start the pop walk");

endmodule
